@@ rtl/core/mscg_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-stop color gradient package
// Shared types and constants for the gradient pipeline.
// ----------------------------------------------------------------------------
package mscg_pkg;

    localparam int MAX_STOPS   = 6;
    localparam int RES_W       = 16;
    localparam int CNT_W       = 3;
    localparam int COLOR_W     = 24;
    localparam int IDX_W       = 3;
    localparam int PCT_W       = 7;   // percent is 0..100
    localparam int NUM_W       = 23;  // offset * 100
    localparam int PCT_SCALE   = 100;

    // exact reciprocals for 16-bit dividends
    localparam logic [15:0] RECIP3    = 16'd43691;
    localparam int          RECIP3_SH = 17;
    localparam logic [15:0] RECIP5    = 16'd52429;
    localparam int          RECIP5_SH = 18;
    // exact for magnitudes up to 25599
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP100_SH = 19;

    // configuration register indexes
    localparam logic [2:0] CFG_RESOLUTION  = 3'd0;
    localparam logic [2:0] CFG_COLOR_COUNT = 3'd1;
    localparam logic [2:0] CFG_STOP_BASE   = 3'd2;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_BLACK,
        MODE_STOP,
        MODE_FAULT
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [IDX_W-1:0]  idx;
    } t_side;

endpackage

@@ rtl/core/multi_stop_color_gradient_unit.sv @@
// Each accepted position passes through registered stages A, B, C, the divider, E and F in order.
// Throughput: one position per cycle; the pipeline stalls as a whole when
// the output beat is not taken.
// Percent division takes 7 stages, one quotient bit each.
// Synchronous active-low reset clears valid bits and all config registers.
// ----------------------------------------------------------------------------
// Multi-stop color gradient unit
// Maps a gradient position to an RGB color interpolated between stops.
// ----------------------------------------------------------------------------
module multi_stop_color_gradient_unit
    import mscg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_index,
    input  logic [23:0]   i_cfg_data,
    output logic          o_cfg_ready,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_position,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue,
    output logic          o_div_fault
);

    logic [RES_W-1:0]   r_resolution;
    logic [CNT_W-1:0]   r_color_count;
    logic [COLOR_W-1:0] r_stop [MAX_STOPS];
    logic [2:0]         n_stop_sel;

    logic en;
    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    assign n_stop_sel = i_cfg_index - CFG_STOP_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution  <= '0;
            r_color_count <= '0;
            for (int i = 0; i < MAX_STOPS; i++) r_stop[i] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RESOLUTION:  r_resolution  <= i_cfg_data[RES_W-1:0];
                CFG_COLOR_COUNT: r_color_count <= i_cfg_data[CNT_W-1:0];
                default: begin
                    if (n_stop_sel < 3'(MAX_STOPS)) r_stop[n_stop_sel] <= i_cfg_data;
                end
            endcase
        end
    end

    // stage A: classify, reciprocal product
    logic [CNT_W-1:0] n_cnt, n_dm;
    t_side            n_a_side;
    logic [15:0]      n_recip;
    logic             r_a_v;
    logic [31:0]      r_a_prod;
    logic [15:0]      r_a_pos;
    logic [CNT_W-1:0] r_a_dm;
    t_side            r_a_side;

    always_comb begin
        n_cnt = (r_color_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : r_color_count;
        n_dm  = n_cnt - 3'd1;
        n_a_side.idx = '0;
        if (n_cnt == '0 || r_resolution == '0) begin
            n_a_side.mode = MODE_BLACK;
        end else if (n_cnt == 3'd1) begin
            n_a_side.mode = MODE_STOP;
        end else if (i_position >= r_resolution) begin
            n_a_side.mode = MODE_STOP;
            n_a_side.idx  = n_dm;
        end else begin
            n_a_side.mode = MODE_NORMAL;
        end
        case (n_dm)
            3'd3:    n_recip = RECIP3;
            3'd5:    n_recip = RECIP5;
            default: n_recip = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en)  r_a_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_prod <= 32'(r_resolution) * 32'(n_recip);
            r_a_pos  <= i_position;
            r_a_dm   <= n_dm;
            r_a_side <= n_a_side;
        end
    end

    // stage B: segment length
    logic [RES_W-1:0] n_seg;
    logic             r_b_v;
    logic [RES_W-1:0] r_b_seg;
    logic [15:0]      r_b_pos;
    logic [CNT_W-1:0] r_b_dm;
    t_side            r_b_side;

    always_comb begin
        case (r_a_dm)
            3'd1:    n_seg = r_resolution;
            3'd2:    n_seg = r_resolution >> 1;
            3'd3:    n_seg = RES_W'(r_a_prod >> RECIP3_SH);
            3'd4:    n_seg = r_resolution >> 2;
            3'd5:    n_seg = RES_W'(r_a_prod >> RECIP5_SH);
            default: n_seg = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (en)  r_b_v <= r_a_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_seg  <= n_seg;
            r_b_pos  <= r_a_pos;
            r_b_dm   <= r_a_dm;
            r_b_side <= r_a_side;
        end
    end

    // stage C: segment index and offset by compare against multiples
    logic [18:0]      n_mult [MAX_STOPS];
    logic [MAX_STOPS-1:0] n_ge;
    logic [IDX_W-1:0] n_idx;
    logic [15:0]      n_off;
    logic             n_past;
    t_side            n_c_side;
    logic             r_c_v;
    logic [NUM_W-1:0] r_c_num;
    logic [RES_W-1:0] r_c_den;
    t_side            r_c_side;

    always_comb begin
        n_idx = '0;
        for (int k = 0; k < MAX_STOPS; k++) begin
            n_mult[k] = 19'(r_b_seg) * 19'(k);
            n_ge[k]   = (19'(r_b_pos) >= n_mult[k]);
        end
        for (int k = 1; k < MAX_STOPS; k++) begin
            if (n_ge[k]) n_idx = n_idx + 3'd1;
        end
        n_past = (r_b_dm != '0) && n_ge[r_b_dm];
        n_off  = 16'(19'(r_b_pos) - n_mult[n_idx]);
        n_c_side = r_b_side;
        if (r_b_side.mode == MODE_NORMAL) begin
            n_c_side.idx = n_idx;
            if (r_b_seg == '0) n_c_side.mode = MODE_FAULT;
            else if (n_past) n_c_side.mode = MODE_BLACK;
            else if (r_b_seg == 16'd1) n_c_side.mode = MODE_FAULT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (en)  r_c_v <= r_b_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_num  <= NUM_W'(n_off) * NUM_W'(PCT_SCALE);
            r_c_den  <= r_b_seg - 16'd1;
            r_c_side <= n_c_side;
        end
    end

    // stages D: percent = offset*100 / (seg-1)
    logic             d_v;
    logic [PCT_W-1:0] d_pct;
    t_side            d_side;

    mscg_pct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_v),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_side  (r_c_side),
        .o_valid (d_v),
        .o_pct   (d_pct),
        .o_side  (d_side)
    );

    // stage E: pct * (end - start) per channel
    logic [COLOR_W-1:0] n_ca, n_cb;
    logic [IDX_W-1:0]   n_idx1;
    logic               r_e_v;
    logic signed [15:0] r_e_prod [3];
    logic [7:0]         r_e_start [3];
    t_side              r_e_side;

    always_comb begin
        n_idx1 = d_side.idx + 3'd1;
        n_ca = (d_side.idx < 3'(MAX_STOPS)) ? r_stop[d_side.idx] : '0;
        n_cb = (n_idx1 < 3'(MAX_STOPS)) ? r_stop[n_idx1] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_v <= 1'b0;
        else if (en)  r_e_v <= d_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_e_start[c] <= n_ca[23-8*c -: 8];
                // all operands 16 bits signed, product fits in +/-25500
                r_e_prod[c]  <= $signed({9'd0, d_pct}) *
                                ($signed({8'd0, n_cb[23-8*c -: 8]})
                                 - $signed({8'd0, n_ca[23-8*c -: 8]}));
            end
            r_e_side <= d_side;
        end
    end

    // stage F: divide by 100 toward zero, add start, pick result
    logic [14:0]        n_mag [3];
    logic [7:0]         n_q   [3];
    logic [7:0]         n_ch  [3];
    logic [COLOR_W-1:0] n_rgb, n_stop_c;
    logic               n_fault;
    logic               r_o_v;
    logic [COLOR_W-1:0] r_o_rgb;
    logic               r_o_fault;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_mag[c] = r_e_prod[c][15] ? 15'(-r_e_prod[c]) : 15'(r_e_prod[c]);
            n_q[c]   = 8'((28'(n_mag[c]) * 28'(RECIP100)) >> RECIP100_SH);
            n_ch[c]  = r_e_prod[c][15] ? r_e_start[c] - n_q[c] : r_e_start[c] + n_q[c];
        end
        n_stop_c = (r_e_side.idx < 3'(MAX_STOPS)) ? r_stop[r_e_side.idx] : '0;
        n_fault  = 1'b0;
        case (r_e_side.mode)
            MODE_NORMAL: n_rgb = {n_ch[0], n_ch[1], n_ch[2]};
            MODE_STOP:   n_rgb = n_stop_c;
            MODE_FAULT: begin
                n_rgb   = '0;
                n_fault = 1'b1;
            end
            default:     n_rgb = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_v <= 1'b0;
        else if (en)  r_o_v <= r_e_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_rgb   <= n_rgb;
            r_o_fault <= n_fault;
        end
    end

    assign o_valid     = r_o_v;
    assign o_red       = r_o_rgb[23:16];
    assign o_green     = r_o_rgb[15:8];
    assign o_blue      = r_o_rgb[7:0];
    assign o_div_fault = r_o_fault;

    a_fault_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_fault |-> r_o_rgb == '0)
        else $error("fault beat carries a color");

    a_fault_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_fault |-> r_color_count >= 3'd2)
        else $error("fault with fewer than two stops");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_e_v)
        else $error("valid beat after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_e_side) && $stable(r_c_num))
        else $error("pipeline moved during stall");

endmodule

@@ rtl/core/mscg_pct_div.sv @@
// ----------------------------------------------------------------------------
// Percent divider
// Restoring divider, one quotient bit per pipeline stage, MSB first.
// ----------------------------------------------------------------------------
module mscg_pct_div
    import mscg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [RES_W-1:0]  i_den,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [PCT_W-1:0]  o_pct,
    output t_side             o_side
);

    logic              s_v    [PCT_W+1];
    logic [NUM_W-1:0]  s_rem  [PCT_W+1];
    logic [PCT_W-1:0]  s_q    [PCT_W+1];
    logic [RES_W-1:0]  s_den  [PCT_W+1];
    t_side             s_side [PCT_W+1];

    assign s_v[0]    = i_valid;
    assign s_rem[0]  = i_num;
    assign s_q[0]    = '0;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    for (genvar gi = 0; gi < PCT_W; gi++) begin : g_stage
        localparam int K = PCT_W - 1 - gi;
        logic              r_v;
        logic [NUM_W-1:0]  r_rem;
        logic [PCT_W-1:0]  r_q;
        logic [RES_W-1:0]  r_den;
        t_side             r_side;
        logic [NUM_W-1:0]  n_trial;
        logic              n_ge;

        assign n_trial = NUM_W'(s_den[gi]) << K;
        assign n_ge    = (s_rem[gi] >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_ge ? s_rem[gi] - n_trial : s_rem[gi];
                r_q    <= s_q[gi] | (PCT_W'(n_ge) << K);
                r_den  <= s_den[gi];
                r_side <= s_side[gi];
            end
        end

        assign s_v[gi+1]    = r_v;
        assign s_rem[gi+1]  = r_rem;
        assign s_q[gi+1]    = r_q;
        assign s_den[gi+1]  = r_den;
        assign s_side[gi+1] = r_side;
    end

    assign o_valid = s_v[PCT_W];
    assign o_pct   = s_q[PCT_W];
    assign o_side  = s_side[PCT_W];

endmodule

@@ tb/gradient_checker.sv @@
// ----------------------------------------------------------------------------
// Gradient checker
// Mirrors the palette registers from the config channel, predicts the color
// of every accepted position and compares it with the output beats in order.
// ----------------------------------------------------------------------------
module gradient_checker
    import mscg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_cfg_ready,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [15:0] i_position,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_div_fault,
    output int          o_errors,
    output int          o_pending
);

    logic [15:0] res_q;
    logic [2:0]  cnt_q;
    logic [23:0] stops_q [MAX_STOPS];
    logic [24:0] color_fifo [$];   // {fault, rgb}

    function automatic logic [7:0] mix(logic [7:0] a, logic [7:0] b, int pct);
        int s;
        int e;
        int v;
        s = a;
        e = b;
        v = s + (pct * (e - s)) / 100;   // SV int division truncates toward zero
        return v[7:0];
    endfunction

    function automatic logic [24:0] gradient_color(logic [15:0] pos);
        int cnt;
        int seg;
        int off;
        int idx;
        int pct;
        logic [23:0] a;
        logic [23:0] b;
        cnt = (cnt_q > MAX_STOPS) ? MAX_STOPS : cnt_q;
        if (cnt == 0 || res_q == 0) return 25'd0;
        if (cnt == 1) return {1'b0, stops_q[0]};
        if (pos >= res_q) return {1'b0, stops_q[cnt-1]};
        seg = int'(res_q) / (cnt - 1);
        if (seg == 0) return {1'b1, 24'd0};
        off = int'(pos) % seg;
        idx = int'(pos) / seg;
        if (idx + 1 >= cnt) return 25'd0;
        if (seg == 1) return {1'b1, 24'd0};
        pct = (off * 100) / (seg - 1);
        a = stops_q[idx];
        b = stops_q[idx+1];
        return {1'b0, mix(a[23:16], b[23:16], pct), mix(a[15:8], b[15:8], pct),
                mix(a[7:0], b[7:0], pct)};
    endfunction

    assign o_pending = color_fifo.size();

    always @(posedge i_clk) begin
        logic [24:0] want;
        if (!i_rst_n) begin
            res_q <= '0;
            cnt_q <= '0;
            for (int i = 0; i < MAX_STOPS; i++) stops_q[i] <= '0;
            color_fifo.delete();
            o_errors <= 0;
        end else begin
            if (i_valid && i_ready_in) color_fifo.push_back(gradient_color(i_position));
            if (i_out_valid && i_out_ready) begin
                if (color_fifo.size() == 0) begin
                    $display("%0t: unexpected beat rgb=%02h%02h%02h fault=%0b", $time,
                             i_red, i_green, i_blue, i_div_fault);
                    o_errors <= o_errors + 1;
                end else begin
                    want = color_fifo.pop_front();
                    if ({i_div_fault, i_red, i_green, i_blue} !== want) begin
                        $display({"%0t: mismatch expected rgb=%06h fault=%0b",
                                  " actual rgb=%02h%02h%02h fault=%0b"},
                                 $time, want[23:0], want[24], i_red, i_green, i_blue,
                                 i_div_fault);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_RESOLUTION) res_q <= i_cfg_data[15:0];
                else if (i_cfg_index == CFG_COLOR_COUNT) cnt_q <= i_cfg_data[2:0];
                else if (i_cfg_index >= CFG_STOP_BASE && i_cfg_index < CFG_STOP_BASE + MAX_STOPS)
                    stops_q[i_cfg_index - CFG_STOP_BASE] <= i_cfg_data;
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Gradient unit testbench
// Programs several palettes, drives directed and random positions under
// varied backpressure and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench
    import mscg_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        cfg_ready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] position = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  red, green, blue;
    logic        div_fault;
    int          errors;
    int          pending;
    int          send_idle = 0;   // percent
    int          recv_stall = 0;  // percent
    bit          hold_off = 1'b0;
    int          quiet = 0;

    always #6 clk = ~clk;

    multi_stop_color_gradient_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_cfg_ready(cfg_ready),
        .i_valid(in_valid), .o_ready(in_ready), .i_position(position),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_red(red), .o_green(green), .o_blue(blue), .o_div_fault(div_fault)
    );

    gradient_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_cfg_ready(cfg_ready),
        .i_valid(in_valid), .i_ready_in(in_ready), .i_position(position),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_red(red), .i_green(green), .i_blue(blue), .i_div_fault(div_fault),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high between back-to-back writes; program_palette drops it
    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // valid stays high after the beat unless the next one idles first
    task automatic send_position(logic [15:0] pos);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        position <= pos;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic program_palette(logic [15:0] res, logic [2:0] cnt);
        drain();
        write_reg(CFG_RESOLUTION, {8'd0, res});
        write_reg(CFG_COLOR_COUNT, {21'd0, cnt});
        for (int i = 0; i < MAX_STOPS; i++)
            write_reg(CFG_STOP_BASE + 3'(i), 24'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    // mostly positions inside the gradient, some beyond it
    function automatic logic [15:0] pick_position(logic [15:0] res);
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'hFFFF;
        if (r < 15) return 16'($urandom());
        if (res == 0) return 16'($urandom_range(3));
        return 16'($urandom_range(int'(res) - 1));
    endfunction

    initial begin
        logic [15:0] res;
        logic [2:0]  cnt;
        logic [15:0] dir [$];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset palette: black
        send_position(16'd0);
        send_position(16'hFFFF);
        // directed: special segment lengths and extremes
        program_palette(16'hFFFF, 3'd6);
        dir = '{16'd0, 16'd13106, 16'd13107, 16'd65534, 16'hFFFF, 16'h5555, 16'hAAAA};
        foreach (dir[i]) send_position(dir[i]);
        program_palette(16'd3, 3'd6);      // segment length zero
        send_position(16'd0); send_position(16'd2); send_position(16'd3);
        program_palette(16'd7, 3'd6);      // length one, leftover positions
        send_position(16'd0); send_position(16'd4); send_position(16'd5);
        send_position(16'd6);
        program_palette(16'd100, 3'd1);    // single stop
        send_position(16'd50);
        program_palette(16'd100, 3'd7);    // count saturates
        send_position(16'd99); send_position(16'd20);
        program_palette(16'd0, 3'd3);      // zero resolution
        send_position(16'd0);
        program_palette(16'd50, 3'd0);     // empty palette
        send_position(16'd1);
        // random phases
        for (int ph = 0; ph < 28; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 62; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 62; end
                default: begin send_idle = 24; recv_stall = 24; end
            endcase
            cnt = 3'($urandom_range(7));
            case ($urandom_range(3))
                0: res = 16'($urandom_range(12));
                1: res = 16'($urandom_range(600));
                2: res = 16'hFFFF;
                default: res = 16'($urandom());
            endcase
            program_palette(res, cnt);
            if (ph == 5) begin
                hold_off = 1'b1;
                fork
                    begin repeat (300) @(posedge clk); hold_off = 1'b0; end
                join_none
            end
            for (int k = 0; k < 50; k++) send_position(pick_position(res));
        end
        hold_off = 1'b0;
        drain();
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
